>>> rtl/bsrc_pkg.sv
// ---------------------------------------------------------------------------
// bsrc_pkg: shared definitions for the batch send retry controller
// Request codes, result codes, statistics indices, register map and the
// result record that travels from the core to the output stage.
// ---------------------------------------------------------------------------
`default_nettype none

package bsrc_pkg;

   // Request kinds carried in tuser
   localparam logic [2:0] OP_ARRIVE    = 3'd0;
   localparam logic [2:0] OP_TICK      = 3'd1;
   localparam logic [2:0] OP_OUTCOME   = 3'd2;
   localparam logic [2:0] OP_SHUTDOWN  = 3'd3;
   localparam logic [2:0] OP_READ_STAT = 3'd4;

   // Result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_REJECTED  = 2'd2;
   localparam logic [1:0] ST_IGNORED   = 2'd3;

   // Statistics counter indices
   localparam int STAT_COUNT = 8;
   localparam int STAT_EMITTED   = 0;
   localparam int STAT_DROP_FULL = 1;
   localparam int STAT_DROP_ERR  = 2;
   localparam int STAT_SENT      = 3;
   localparam int STAT_2XX       = 4;
   localparam int STAT_4XX       = 5;
   localparam int STAT_RETRY     = 6;
   localparam int STAT_NET_ERR   = 7;

   // Register map
   localparam logic [2:0] CSR_BATCH_SIZE    = 3'd0;
   localparam logic [2:0] CSR_AGE_LIMIT     = 3'd1;
   localparam logic [2:0] CSR_MAX_RETRIES   = 3'd2;
   localparam logic [2:0] CSR_BACKOFF_INIT  = 3'd3;
   localparam logic [2:0] CSR_BACKOFF_MAX   = 3'd4;

   // Register reset values
   localparam logic [9:0]  RST_BATCH_SIZE   = 10'd512;
   localparam logic [15:0] RST_AGE_LIMIT    = 16'd100;
   localparam logic [7:0]  RST_MAX_RETRIES  = 8'd5;
   localparam logic [31:0] RST_BACKOFF_INIT = 32'd1000;
   localparam logic [31:0] RST_BACKOFF_MAX  = 32'd30000;

   // HTTP status boundaries
   localparam logic [9:0] HTTP_NET_FAIL   = 10'd0;
   localparam logic [9:0] HTTP_2XX_LO     = 10'd200;
   localparam logic [9:0] HTTP_2XX_HI     = 10'd300;
   localparam logic [9:0] HTTP_TOO_MANY   = 10'd429;
   localparam logic [9:0] HTTP_5XX_LO     = 10'd500;
   localparam logic [9:0] HTTP_5XX_HI     = 10'd600;

   // Width of the item counts shown on the result channel
   localparam int COUNT_W = 11;
   localparam int SHIFT_LIMIT = 32;

   typedef logic [STAT_COUNT-1:0] stat_bump_type;

   // Result record, first member in the highest bits
   typedef struct packed {
      logic [63:0]        stat_value;
      logic [7:0]         attempt;
      logic               retry_wait;
      logic               busy;
      logic [COUNT_W-1:0] held_count;
      logic [COUNT_W-1:0] send_count;
      logic               send_start;
      logic [1:0]         status;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/bsrc_stats.sv
// ---------------------------------------------------------------------------
// bsrc_stats: statistics counter bank
// Eight wrapping 64-bit counters. Each counter has its own adder; the sent
// and dropped-error counters add a batch size, the others count by one.
// ---------------------------------------------------------------------------
`default_nettype none

module bsrc_stats
   import bsrc_pkg::*;
#(
   parameter int AmountW = 11
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire stat_bump_type      bump,
   input  wire logic [AmountW-1:0] amount,
   input  wire logic [2:0]         rd_sel,
   output logic      [63:0]        rd_value
);

   logic [63:0] counters_ff [STAT_COUNT];
   logic [63:0] counters_in [STAT_COUNT];

   // Next value of every counter.
   always_comb begin
      for (int i = 0; i < STAT_COUNT; i++) begin
         if (!bump[i]) begin
            counters_in[i] = counters_ff[i];
         end else if (i == STAT_SENT || i == STAT_DROP_ERR) begin
            counters_in[i] = counters_ff[i] + 64'(amount);
         end else begin
            counters_in[i] = counters_ff[i] + 64'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STAT_COUNT; i++) begin
         if (reset) begin
            counters_ff[i] <= '0;
         end else begin
            counters_ff[i] <= counters_in[i];
         end
      end
   end

   assign rd_value = counters_ff[rd_sel];

endmodule

`default_nettype wire

>>> rtl/bsrc_core.sv
// ---------------------------------------------------------------------------
// bsrc_core: batch and retry state with configuration registers
// Applies one accepted request per cycle to the batch state, works out the result
// record and the statistics updates, then runs the send start check.
// ---------------------------------------------------------------------------
`default_nettype none

module bsrc_core
   import bsrc_pkg::*;
#(
   parameter int PENDING_CAPACITY = 1024,
   localparam int HeldW = $clog2(PENDING_CAPACITY + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wen,
   input  wire logic [2:0]       csr_index,
   input  wire logic [31:0]      csr_wdata,
   input  wire logic             req_fire,
   input  wire logic [2:0]       req_op,
   input  wire logic [9:0]       req_code,
   input  wire logic [2:0]       req_sel,
   input  wire logic [63:0]      stat_rd_value,
   output logic      [2:0]       stat_rd_sel,
   output stat_bump_type         stat_bump,
   output logic      [HeldW-1:0] stat_amount,
   output rsp_type               rsp
);

   localparam int CmpW = (HeldW > 10) ? HeldW : 10;
   localparam int ExtW = (HeldW > COUNT_W) ? HeldW : COUNT_W;

   // Configuration registers
   logic [9:0]  batch_size_ff;
   logic [15:0] age_limit_ff;
   logic [7:0]  max_retries_ff;
   logic [31:0] backoff_init_ff;
   logic [31:0] backoff_max_ff;

   // Batch state
   logic [HeldW-1:0] held_ff, held_in;
   logic             age_run_ff, age_run_in;
   logic [15:0]      age_ff, age_in;
   logic             sending_ff, sending_in;
   logic [HeldW-1:0] scount_ff, scount_in;
   logic [7:0]       fails_ff, fails_in;
   logic [31:0]      delay_ff, delay_in;
   logic             armed_ff, armed_in;
   logic             stopping_ff, stopping_in;

   logic [63:0]      shifted;
   logic             backoff_over;
   logic [31:0]      backoff;
   logic [8:0]       fail_next;
   logic [ExtW-1:0]  held_ext;
   logic [ExtW-1:0]  start_ext;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         batch_size_ff   <= RST_BATCH_SIZE;
         age_limit_ff    <= RST_AGE_LIMIT;
         max_retries_ff  <= RST_MAX_RETRIES;
         backoff_init_ff <= RST_BACKOFF_INIT;
         backoff_max_ff  <= RST_BACKOFF_MAX;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_BATCH_SIZE:   batch_size_ff   <= csr_wdata[9:0];
            CSR_AGE_LIMIT:    age_limit_ff    <= csr_wdata[15:0];
            CSR_MAX_RETRIES:  max_retries_ff  <= csr_wdata[7:0];
            CSR_BACKOFF_INIT: backoff_init_ff <= csr_wdata;
            CSR_BACKOFF_MAX:  backoff_max_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Backoff delay for the next retry: initial value doubled per earlier failure,
   // capped at the maximum and saturated to it when the shift overflows.
   always_comb begin
      shifted      = {32'd0, backoff_init_ff} << fails_ff[4:0];
      backoff_over = (fails_ff >= 8'(SHIFT_LIMIT)) || (shifted[63:32] != 32'd0) ||
                     (shifted[31:0] > backoff_max_ff);
      backoff      = backoff_over ? backoff_max_ff : shifted[31:0];
      fail_next    = {1'b0, fails_ff} + 9'd1;
   end

   // Request handling followed by the send start check.
   always_comb begin
      logic finish;
      logic retry;
      logic drop;
      logic [31:0] delay_dec;

      finish      = 1'b0;
      retry       = 1'b0;
      drop        = 1'b0;
      delay_dec   = '0;
      held_in     = held_ff;
      age_run_in  = age_run_ff;
      age_in      = age_ff;
      sending_in  = sending_ff;
      scount_in   = scount_ff;
      fails_in    = fails_ff;
      delay_in    = delay_ff;
      armed_in    = armed_ff;
      stopping_in = stopping_ff;
      stat_bump   = '0;
      stat_amount = scount_ff;
      stat_rd_sel = req_sel;
      rsp         = '0;
      rsp.status  = ST_OK;

      case (req_op)
         OP_ARRIVE: begin
            if (stopping_ff) begin
               rsp.status = ST_REJECTED;
            end else if (held_ff >= HeldW'(PENDING_CAPACITY)) begin
               rsp.status = ST_FULL;
               stat_bump[STAT_DROP_FULL] = 1'b1;
            end else begin
               held_in = held_ff + HeldW'(1);
               stat_bump[STAT_EMITTED] = 1'b1;
               if (!age_run_ff) begin
                  age_run_in = 1'b1;
                  age_in     = '0;
               end
            end
         end
         OP_TICK: begin
            if (age_run_ff && age_ff != 16'hFFFF) begin
               age_in = age_ff + 16'd1;
            end
            // Retry delay count-down; the resend starts when it reaches zero.
            if (armed_ff && !sending_ff) begin
               delay_dec = (delay_ff != 32'd0) ? delay_ff - 32'd1 : 32'd0;
               delay_in  = delay_dec;
               if (delay_dec == 32'd0) begin
                  armed_in = 1'b0;
                  if (held_ff != '0) begin
                     sending_in     = 1'b1;
                     scount_in      = held_ff;
                     age_run_in     = 1'b0;
                     age_in         = '0;
                     rsp.send_start = 1'b1;
                     start_ext      = ExtW'(held_ff);
                  end
               end
            end
         end
         OP_OUTCOME: begin
            if (!sending_ff) begin
               rsp.status = ST_IGNORED;
            end else begin
               if (req_code == HTTP_NET_FAIL) begin
                  stat_bump[STAT_NET_ERR] = 1'b1;
                  retry = 1'b1;
               end else if (req_code >= HTTP_2XX_LO && req_code < HTTP_2XX_HI) begin
                  stat_bump[STAT_2XX]  = 1'b1;
                  stat_bump[STAT_SENT] = 1'b1;
                  finish = 1'b1;
               end else if (req_code == HTTP_TOO_MANY ||
                            (req_code >= HTTP_5XX_LO && req_code < HTTP_5XX_HI)) begin
                  stat_bump[STAT_RETRY] = 1'b1;
                  retry = 1'b1;
               end else begin
                  stat_bump[STAT_4XX] = 1'b1;
                  drop = 1'b1;
               end
               if (retry) begin
                  if (fail_next > {1'b0, max_retries_ff}) begin
                     drop = 1'b1;
                  end else begin
                     fails_in = fail_next[7:0];
                     delay_in = backoff;
                     armed_in = 1'b1;
                  end
               end
               if (drop) begin
                  stat_bump[STAT_DROP_ERR] = 1'b1;
                  finish = 1'b1;
               end
               // Only the items that were in flight leave the store.
               if (finish) begin
                  held_in  = (held_ff >= scount_ff) ? held_ff - scount_ff : '0;
                  fails_in = '0;
                  armed_in = 1'b0;
                  delay_in = '0;
               end
               sending_in = 1'b0;
               scount_in  = '0;
            end
         end
         OP_SHUTDOWN: begin
            stopping_in = 1'b1;
         end
         OP_READ_STAT: begin
            rsp.stat_value = stat_rd_value;
         end
         default: ;
      endcase

      // Send start check on the updated state.
      if (!sending_in && !armed_in && held_in != '0 &&
          (CmpW'(held_in) >= CmpW'(batch_size_ff) ||
           (age_run_in && age_in >= age_limit_ff) || stopping_in)) begin
         sending_in     = 1'b1;
         scount_in      = held_in;
         age_run_in     = 1'b0;
         age_in         = '0;
         rsp.send_start = 1'b1;
      end

      held_ext        = ExtW'(held_in);
      start_ext       = rsp.send_start ? ExtW'(scount_in) : '0;
      rsp.send_count  = start_ext[COUNT_W-1:0];
      rsp.held_count  = held_ext[COUNT_W-1:0];
      rsp.busy        = sending_in;
      rsp.retry_wait  = armed_in;
      rsp.attempt     = fails_in;
      if (!req_fire) begin
         stat_bump = '0;
      end
   end

   // State update on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff     <= '0;
         age_run_ff  <= 1'b0;
         age_ff      <= '0;
         sending_ff  <= 1'b0;
         scount_ff   <= '0;
         fails_ff    <= '0;
         delay_ff    <= '0;
         armed_ff    <= 1'b0;
         stopping_ff <= 1'b0;
      end else if (req_fire) begin
         held_ff     <= held_in;
         age_run_ff  <= age_run_in;
         age_ff      <= age_in;
         sending_ff  <= sending_in;
         scount_ff   <= scount_in;
         fails_ff    <= fails_in;
         delay_ff    <= delay_in;
         armed_ff    <= armed_in;
         stopping_ff <= stopping_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/bsrc_skid.sv
// ---------------------------------------------------------------------------
// bsrc_skid: result register with skid stage
// Holds the result being offered and catches one more while the receiver
// stalls, so that the request side keeps moving for one extra request.
// ---------------------------------------------------------------------------
`default_nettype none

module bsrc_skid
   import bsrc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire rsp_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output rsp_type      out_data
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    in_fire;

   assign in_ready = !skid_valid_ff;
   assign in_fire  = in_valid && in_ready;

   // Refill the output register when it is empty or being taken.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         out_valid_in  = skid_valid_ff || in_fire;
         out_data_in   = skid_valid_ff ? skid_data_ff : in_data;
         skid_valid_in = 1'b0;
      end else if (in_fire) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

`default_nettype wire

>>> rtl/batch_send_retry_controller.sv
// ---------------------------------------------------------------------------
// batch_send_retry_controller: batching sender with exponential backoff retry
//
// Requests arrive on the req_ stream; tuser carries the request kind (item
// arrival, millisecond tick, send outcome, shutdown, statistic read) and
// tdata the HTTP status and the statistic index. Each request gives exactly
// one result on the rsp_ stream: status, send start and size, pending count,
// in-flight and backoff flags, retry attempt and the statistic read.
// Registers must be written on the csr_ port only while no request is
// outstanding; the user is bound by this, the block does not enforce it.
// One request is accepted every cycle while req_tready is high; the whole
// update passes once through the core between state and result registers.
// When the receiver stalls, the result register holds and a skid stage takes
// one more request, after which req_tready falls until the stall clears.
// Synchronous reset clears the batch state and the eight 64-bit statistics
// counters and loads the register defaults (512, 100, 5, 1000, 30000).
// ---------------------------------------------------------------------------
`default_nettype none

module batch_send_retry_controller
   import bsrc_pkg::*;
#(
   parameter int PENDING_CAPACITY = 1024
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // Configuration
   input  wire logic         csr_wen,
   input  wire logic [2:0]   csr_index,
   input  wire logic [31:0]  csr_wdata,
   // Requests
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [15:0]  req_tdata,  // result_code[9:0], stat_index[12:10], zero
   input  wire logic [2:0]   req_tuser,  // operation[2:0]
   // Results
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status[1:0], send_start[2], send_count[13:3], held_count[24:14],
   // busy[25], retry_wait[26], attempt[34:27], stat_value[98:35], zero
   output logic [103:0]      rsp_tdata
);

   localparam int HeldW = $clog2(PENDING_CAPACITY + 1);
   localparam int PadW  = 104 - $bits(rsp_type);

   logic             req_fire;
   logic [2:0]       stat_rd_sel;
   logic [63:0]      stat_rd_value;
   stat_bump_type    stat_bump;
   logic [HeldW-1:0] stat_amount;
   rsp_type          core_rsp;
   rsp_type          out_rsp;

   assign req_fire = req_tvalid && req_tready;

   bsrc_core #(
      .PENDING_CAPACITY(PENDING_CAPACITY)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .csr_wen       (csr_wen),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_fire      (req_fire),
      .req_op        (req_tuser),
      .req_code      (req_tdata[9:0]),
      .req_sel       (req_tdata[12:10]),
      .stat_rd_value (stat_rd_value),
      .stat_rd_sel   (stat_rd_sel),
      .stat_bump     (stat_bump),
      .stat_amount   (stat_amount),
      .rsp           (core_rsp)
   );

   bsrc_stats #(
      .AmountW(HeldW)
   ) u_stats (
      .clock    (clock),
      .reset    (reset),
      .bump     (stat_bump),
      .amount   (stat_amount),
      .rd_sel   (stat_rd_sel),
      .rd_value (stat_rd_value)
   );

   bsrc_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (core_rsp),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_rsp)
   );

   assign rsp_tdata = {{PadW{1'b0}}, out_rsp};

   // A send is never in flight while a retry delay runs.
   a_flight_xor_backoff: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(out_rsp.busy && out_rsp.retry_wait))
      else $error("in-flight send and armed backoff at the same time");

   // A started send is in flight after its step.
   a_start_in_flight: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_rsp.send_start) |-> out_rsp.busy)
      else $error("send started without being in flight");

   // Back-pressure on requests only while a result waits.
   a_stall_has_result: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && $past(rsp_tvalid)))
      else $error("request side stalled with no result waiting");

endmodule

`default_nettype wire

>>> dv/batch_send_retry_controller_tb.sv
// ---------------------------------------------------------------------------
// batch_send_retry_controller_tb: self-checking bench for the batch sender
// Requests go in on the req_ stream from a backlog queue, and a predictor of
// the batch, age, retry and statistics state works out one result for each
// accepted request. Every result on the rsp_ stream is checked field by
// field against the oldest prediction. Phases under several register settings,
// the extremes among them, run with random gaps on none, one or both streams.
// ---------------------------------------------------------------------------
`default_nettype none

module batch_send_retry_controller_tb;
   import bsrc_pkg::*;

   localparam int HOLD_CAPACITY = 1024;
   localparam int QUIET_LIMIT   = 4000;
   localparam int PRINT_LIMIT   = 50;

   // Operation codes with no action of their own; the start check still runs
   localparam logic [2:0] OP_SPARE_5 = 3'd5;
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   // Gap settings of the two streams
   localparam int IDLE_NONE = 0;
   localparam int IDLE_SEND = 1;
   localparam int IDLE_RECV = 2;
   localparam int IDLE_BOTH = 3;

   typedef struct packed {
      logic [2:0] op;
      logic [9:0] code;
      logic [2:0] sel;
   } sender_req_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         csr_wen    = 1'b0;
   logic [2:0]   csr_index  = '0;
   logic [31:0]  csr_wdata  = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [15:0]  req_tdata  = '0;   // result_code[9:0], stat_index[12:10], zero
   logic [2:0]   req_tuser  = '0;   // operation[2:0]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // status[1:0], send_start[2], send_count[13:3], held_count[24:14],
   // busy[25], retry_wait[26], attempt[34:27], stat_value[98:35], zero
   logic [103:0] rsp_tdata;

   batch_send_retry_controller #(.PENDING_CAPACITY(HOLD_CAPACITY)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // Register copies kept by the predictor
   logic [9:0]  cfg_batch     = RST_BATCH_SIZE;
   logic [15:0] cfg_age_limit = RST_AGE_LIMIT;
   logic [7:0]  cfg_retries   = RST_MAX_RETRIES;
   logic [31:0] cfg_bo_init   = RST_BACKOFF_INIT;
   logic [31:0] cfg_bo_max    = RST_BACKOFF_MAX;

   // Sender state kept by the predictor
   logic [10:0] m_held       = '0;
   logic        m_age_on     = 1'b0;
   logic [15:0] m_age        = '0;
   logic        m_busy       = 1'b0;
   logic [10:0] m_busy_count = '0;
   logic [7:0]  m_fails      = '0;
   logic [31:0] m_delay      = '0;
   logic        m_delay_on   = 1'b0;
   logic        m_stop       = 1'b0;
   logic [63:0] m_stats [STAT_COUNT];

   rsp_type        step_rsp;
   sender_req_type req_backlog [$];
   sender_req_type held_req;
   rsp_type        due_results [$];
   rsp_type        seen_rsp;
   rsp_type        want_rsp;
   int             send_gap_pct = 0;
   int             recv_gap_pct = 0;
   int             mismatches   = 0;
   int             results_seen = 0;
   int             quiet_cycles = 0;

   initial begin
      for (int k = 0; k < STAT_COUNT; k++) begin
         m_stats[k] = '0;
      end
   end

   // Start a send of every held item, unless one is already out.
   function automatic void open_send();
      if (!m_busy && m_held != 0) begin
         m_busy             = 1'b1;
         m_busy_count       = m_held;
         m_age_on           = 1'b0;
         m_age              = '0;
         step_rsp.send_start = 1'b1;
         step_rsp.send_count = m_held;
      end
   endfunction

   // Completion and dropping both remove only the items that were in flight.
   function automatic void close_batch();
      m_held     = (m_held >= m_busy_count) ? m_held - m_busy_count : '0;
      m_fails    = '0;
      m_delay_on = 1'b0;
      m_delay    = '0;
   endfunction

   function automatic void drop_batch();
      m_stats[STAT_DROP_ERR] += 64'(m_busy_count);
      close_batch();
   endfunction

   // Arm the doubled delay, capped, or give up past the retry limit.
   function automatic void retry_or_drop();
      int          next;
      int          sh;
      logic [63:0] d;
      next = m_fails + 1;
      if (next > cfg_retries) begin
         drop_batch();
      end else begin
         m_fails = next[7:0];
         sh      = next - 1;
         if (sh >= SHIFT_LIMIT) begin
            d = {32'd0, cfg_bo_max};
         end else begin
            d = {32'd0, cfg_bo_init} << sh;
            if (d > 64'hFFFF_FFFF || d > {32'd0, cfg_bo_max})
               d = {32'd0, cfg_bo_max};
         end
         m_delay    = d[31:0];
         m_delay_on = 1'b1;
      end
   endfunction

   // Work out the result of one request and move the sender state on.
   function automatic void advance_sender(sender_req_type rq);
      step_rsp = '0;
      case (rq.op)
         OP_ARRIVE: begin
            if (m_stop) begin
               step_rsp.status = ST_REJECTED;
            end else if (m_held >= HOLD_CAPACITY) begin
               step_rsp.status = ST_FULL;
               m_stats[STAT_DROP_FULL]++;
            end else begin
               m_held++;
               m_stats[STAT_EMITTED]++;
               if (!m_age_on) begin
                  m_age_on = 1'b1;
                  m_age    = '0;
               end
            end
         end
         OP_TICK: begin
            if (m_age_on && m_age != 16'hFFFF)
               m_age++;
            if (m_delay_on && !m_busy) begin
               if (m_delay != 0)
                  m_delay--;
               if (m_delay == 0) begin
                  m_delay_on = 1'b0;
                  open_send();
               end
            end
         end
         OP_OUTCOME: begin
            if (!m_busy) begin
               step_rsp.status = ST_IGNORED;
            end else begin
               if (rq.code == HTTP_NET_FAIL) begin
                  m_stats[STAT_NET_ERR]++;
                  retry_or_drop();
               end else if (rq.code >= HTTP_2XX_LO && rq.code < HTTP_2XX_HI) begin
                  m_stats[STAT_2XX]++;
                  m_stats[STAT_SENT] += 64'(m_busy_count);
                  close_batch();
               end else if (rq.code == HTTP_TOO_MANY ||
                            (rq.code >= HTTP_5XX_LO && rq.code < HTTP_5XX_HI)) begin
                  m_stats[STAT_RETRY]++;
                  retry_or_drop();
               end else begin
                  m_stats[STAT_4XX]++;
                  drop_batch();
               end
               m_busy       = 1'b0;
               m_busy_count = '0;
            end
         end
         OP_SHUTDOWN: begin
            m_stop = 1'b1;
         end
         OP_READ_STAT: begin
            step_rsp.stat_value = m_stats[rq.sel];
         end
         default: begin
         end
      endcase
      // The start check closes every step.
      if (!m_busy && !m_delay_on &&
          (m_held >= cfg_batch || (m_age_on && m_age >= cfg_age_limit) ||
           (m_stop && m_held != 0)))
         open_send();
      step_rsp.held_count = m_held;
      step_rsp.busy       = m_busy;
      step_rsp.retry_wait = m_delay_on;
      step_rsp.attempt    = m_fails;
   endfunction

   function automatic bit draw_gap(int percent);
      return $urandom_range(0, 99) < percent;
   endfunction

   // Random request; a storm keeps every outcome retryable.
   function automatic sender_req_type random_request(bit storm, bit may_stop);
      sender_req_type rq;
      int             pick;
      int             kind;
      rq.sel = 3'($urandom_range(0, 7));
      kind   = storm ? $urandom_range(0, 3) : $urandom_range(0, 9);
      case (kind)
         0:       rq.code = HTTP_NET_FAIL;
         1, 3:    rq.code = 10'($urandom_range(HTTP_5XX_LO, HTTP_5XX_HI - 1));
         2:       rq.code = HTTP_TOO_MANY;
         4, 5, 6: rq.code = 10'($urandom_range(HTTP_2XX_LO, HTTP_2XX_HI - 1));
         default: rq.code = 10'($urandom_range(0, 1023));
      endcase
      pick = $urandom_range(0, 99);
      if (may_stop && pick < 3)
         rq.op = OP_SHUTDOWN;
      else if (pick < 33)
         rq.op = OP_ARRIVE;
      else if (pick < 68)
         rq.op = OP_TICK;
      else if (pick < 90)
         rq.op = OP_OUTCOME;
      else if (pick < 96)
         rq.op = OP_READ_STAT;
      else
         rq.op = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
      return rq;
   endfunction

   task automatic report_mismatch(string what);
      if (mismatches < PRINT_LIMIT)
         $display("mismatch at result %0d: %s", results_seen, what);
      mismatches++;
   endtask

   task automatic push_req(logic [2:0] op, logic [9:0] code, logic [2:0] sel);
      sender_req_type rq;
      rq.op   = op;
      rq.code = code;
      rq.sel  = sel;
      req_backlog.push_back(rq);
   endtask

   task automatic put_reg(logic [2:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_BATCH_SIZE:   cfg_batch     = value[9:0];
         CSR_AGE_LIMIT:    cfg_age_limit = value[15:0];
         CSR_MAX_RETRIES:  cfg_retries   = value[7:0];
         CSR_BACKOFF_INIT: cfg_bo_init   = value;
         CSR_BACKOFF_MAX:  cfg_bo_max    = value;
         default: begin
         end
      endcase
   endtask

   // Sender holds off until every request has its result back.
   task automatic drain();
      do begin
         @(negedge clock);
      end while (req_backlog.size() != 0 || req_tvalid || due_results.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   task automatic set_regs(logic [9:0] batch, logic [15:0] age, logic [7:0] retries,
                           logic [31:0] bo_init, logic [31:0] bo_max);
      drain();
      put_reg(CSR_BATCH_SIZE, {22'd0, batch});
      put_reg(CSR_AGE_LIMIT, {16'd0, age});
      put_reg(CSR_MAX_RETRIES, {24'd0, retries});
      put_reg(CSR_BACKOFF_INIT, bo_init);
      put_reg(CSR_BACKOFF_MAX, bo_max);
      @(posedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_gaps(int mode);
      send_gap_pct = (mode == IDLE_SEND) ? 84 : (mode == IDLE_BOTH) ? 34 : 0;
      recv_gap_pct = (mode == IDLE_RECV) ? 84 : (mode == IDLE_BOTH) ? 34 : 0;
   endtask

   task automatic random_phase(logic [9:0] batch, logic [15:0] age, logic [7:0] retries,
                               logic [31:0] bo_init, logic [31:0] bo_max, int count,
                               int mode, bit storm, bit may_stop);
      set_regs(batch, age, retries, bo_init, bo_max);
      set_gaps(mode);
      for (int n = 0; n < count; n++) begin
         req_backlog.push_back(random_request(storm, may_stop));
      end
   endtask

   // Driver: a request stays on the bus until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            advance_sender(held_req);
            due_results.push_back(step_rsp);
         end
         if (req_backlog.size() != 0 && !draw_gap(send_gap_pct)) begin
            held_req = req_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= held_req.op;
            req_tdata  <= {3'b000, held_req.sel, held_req.code};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: each result is checked against the oldest prediction.
   always @(posedge clock) begin
      rsp_tready <= !draw_gap(recv_gap_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_rsp = rsp_tdata[$bits(rsp_type)-1:0];
         if (due_results.size() == 0) begin
            report_mismatch("result with no request waiting for it");
         end else begin
            want_rsp = due_results.pop_front();
            if (seen_rsp.status !== want_rsp.status)
               report_mismatch($sformatf("status %0d, want %0d",
                                         seen_rsp.status, want_rsp.status));
            if (seen_rsp.send_start !== want_rsp.send_start)
               report_mismatch($sformatf("send_start %0d, want %0d",
                                         seen_rsp.send_start, want_rsp.send_start));
            if (seen_rsp.send_count !== want_rsp.send_count)
               report_mismatch($sformatf("send_count %0d, want %0d",
                                         seen_rsp.send_count, want_rsp.send_count));
            if (seen_rsp.held_count !== want_rsp.held_count)
               report_mismatch($sformatf("held_count %0d, want %0d",
                                         seen_rsp.held_count, want_rsp.held_count));
            if (seen_rsp.busy !== want_rsp.busy)
               report_mismatch($sformatf("busy %0d, want %0d",
                                         seen_rsp.busy, want_rsp.busy));
            if (seen_rsp.retry_wait !== want_rsp.retry_wait)
               report_mismatch($sformatf("retry_wait %0d, want %0d",
                                         seen_rsp.retry_wait, want_rsp.retry_wait));
            if (seen_rsp.attempt !== want_rsp.attempt)
               report_mismatch($sformatf("attempt %0d, want %0d",
                                         seen_rsp.attempt, want_rsp.attempt));
            if (seen_rsp.stat_value !== want_rsp.stat_value)
               report_mismatch($sformatf("stat_value %0d, want %0d",
                                         seen_rsp.stat_value, want_rsp.stat_value));
         end
         results_seen++;
      end
   end

   // Watchdog: ends the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || csr_wen || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** batch_send_retry_controller: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Register defaults: ignored outcome, a held item, spare operations.
      push_req(OP_OUTCOME, HTTP_2XX_LO, 3'd0);
      push_req(OP_ARRIVE, 10'd0, 3'd0);
      push_req(OP_TICK, 10'd0, 3'd0);
      push_req(OP_SPARE_5, 10'd1023, 3'd7);
      push_req(OP_SPARE_6, 10'd0, 3'd0);
      push_req(OP_SPARE_7, 10'd0, 3'd0);
      push_req(OP_READ_STAT, 10'd0, 3'(STAT_EMITTED));

      // Full batch, network failure, resend, retry limit reached.
      set_regs(10'd2, 16'd3, 8'd1, 32'd1, 32'd2);
      push_req(OP_ARRIVE, 10'd0, 3'd0);
      push_req(OP_OUTCOME, HTTP_NET_FAIL, 3'd0);
      push_req(OP_TICK, 10'd0, 3'd0);
      push_req(OP_OUTCOME, 10'd503, 3'd0);
      // Age trigger, too-many-requests retry, then a drop on an odd code.
      push_req(OP_ARRIVE, 10'd0, 3'd0);
      push_req(OP_TICK, 10'd0, 3'd0);
      push_req(OP_TICK, 10'd0, 3'd0);
      push_req(OP_TICK, 10'd0, 3'd0);
      push_req(OP_OUTCOME, HTTP_TOO_MANY, 3'd0);
      push_req(OP_TICK, 10'd0, 3'd0);
      push_req(OP_OUTCOME, 10'd1023, 3'd0);
      // Success, then an informational code that drops.
      push_req(OP_ARRIVE, 10'd0, 3'd0);
      push_req(OP_ARRIVE, 10'd0, 3'd0);
      push_req(OP_OUTCOME, 10'd299, 3'd0);
      push_req(OP_ARRIVE, 10'd0, 3'd0);
      push_req(OP_ARRIVE, 10'd0, 3'd0);
      push_req(OP_OUTCOME, 10'd100, 3'd0);
      for (int k = 0; k < STAT_COUNT; k++) begin
         push_req(OP_READ_STAT, 10'd0, k[2:0]);
      end

      random_phase(10'd4, 16'd5, 8'd3, 32'd2, 32'd8, 40, IDLE_NONE, 1'b0, 1'b0);
      // No retries at all, so every failed send is dropped.
      random_phase(10'd1, 16'd1, 8'd0, 32'd0, 32'd0, 40, IDLE_SEND, 1'b0, 1'b0);
      // Long retry storm: steady server errors walk the shift past 32 bits,
      // then random retryable outcomes follow.
      random_phase(10'd3, 16'hFFFF, 8'd255, 32'd1, 32'd3, 0, IDLE_RECV, 1'b1, 1'b0);
      for (int n = 0; n < 3; n++) begin
         push_req(OP_ARRIVE, 10'd0, 3'd0);
      end
      for (int n = 0; n < 40; n++) begin
         push_req(OP_TICK, 10'd0, 3'd0);
         push_req(OP_TICK, 10'd0, 3'd0);
         push_req(OP_TICK, 10'd0, 3'd0);
         push_req(OP_OUTCOME, 10'd503, 3'd0);
      end
      for (int n = 0; n < 60; n++) begin
         req_backlog.push_back(random_request(1'b1, 1'b0));
      end
      // Zero batch and age limits; the second delay overflows 32 bits.
      random_phase(10'd0, 16'd0, 8'd7, 32'h8000_0000, 32'd5, 40, IDLE_BOTH, 1'b0, 1'b0);
      random_phase(10'd16, 16'd20, 8'd4, 32'hFFFF_FFFF, 32'd6, 40, IDLE_NONE, 1'b0, 1'b0);

      // Store fills while one send is out; later arrivals are dropped.
      set_regs(10'd1, 16'hFFFF, 8'd1, 32'd1, 32'd1);
      set_gaps(IDLE_BOTH);
      for (int n = 0; n < HOLD_CAPACITY + 12; n++) begin
         push_req(OP_ARRIVE, 10'd0, 3'd0);
      end
      push_req(OP_READ_STAT, 10'd0, 3'(STAT_DROP_FULL));
      push_req(OP_OUTCOME, HTTP_2XX_LO, 3'd0);
      push_req(OP_TICK, 10'd0, 3'd0);
      push_req(OP_OUTCOME, 10'd404, 3'd0);
      push_req(OP_TICK, 10'd0, 3'd0);

      random_phase(10'd1023, 16'd8, 8'd5, 32'd3, 32'd10, 40, IDLE_SEND, 1'b0, 1'b0);
      // Shutdown only here: once set, arrivals are refused for good.
      random_phase(10'd512, 16'd6, 8'd5, 32'd2, 32'hFFFF_FFFF, 50, IDLE_RECV, 1'b0, 1'b1);
      push_req(OP_SHUTDOWN, 10'd0, 3'd0);
      push_req(OP_ARRIVE, 10'd0, 3'd0);
      for (int k = 0; k < STAT_COUNT; k++) begin
         push_req(OP_READ_STAT, 10'd0, k[2:0]);
      end
      drain();

      if (mismatches == 0 && due_results.size() == 0) begin
         $display("** batch_send_retry_controller: PASSED **");
      end else begin
         $display("** batch_send_retry_controller: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
rtl/bsrc_pkg.sv
rtl/bsrc_stats.sv
rtl/bsrc_core.sv
rtl/bsrc_skid.sv
rtl/batch_send_retry_controller.sv
dv/batch_send_retry_controller_tb.sv
